// ===== rtl/sawc_pkg.sv =====
// ----------------------------------------------------------------------------
// sawc_pkg
// Shared types and constants for the set-associative write-back cache unit.
// ----------------------------------------------------------------------------
package sawc_pkg;

    localparam int DEF_LINE_BYTES = 64;
    localparam int DEF_WAYS       = 16;
    localparam int DEF_SETS       = 16;
    localparam int DEF_ADDR_BITS  = 20;

    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic [15:0] LFSR_ONE  = 16'h0001;

    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_HALF  = 2'd1;
    localparam logic [1:0] SIZE_WORD  = 2'd2;
    localparam logic [1:0] SIZE_BAD   = 2'd3;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [19:0] address;
        logic [1:0]  size_code;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [2:0]  hit_bytes;
        logic        size_error;
    } rsp_t;

endpackage

// ===== rtl/set_assoc_writeback_cache_unit.sv =====
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_unit
// Byte-serial set-associative write-back cache with random replacement and
// an internal backing memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the backing memory to zero, one byte per cycle;
// req_stall stays high meanwhile. An access is then handled one byte at a time
// by a single sequencer around one tag compare. Each way searched goes through
// a tag memory read and then a compare. A write byte that hits is written to
// the data memory at the compare; a read byte that hits is read from the data
// memory and then captured. A miss searches all WAYS ways, then captures the
// memory byte and advances the LFSR, checks the victim, fetches the victim tag
// and writes the line back if the victim is dirty, refills the line and moves
// to the next byte. Each transaction also has a step to be taken and a step to
// load the result. A result waits in an output register, and a new transaction
// is taken while it waits. Size code 3 returns size_error with no other effect.
// SETS, WAYS and LINE_BYTES must be powers of two.
// ----------------------------------------------------------------------------
module set_assoc_writeback_cache_unit #(
    parameter int LINE_BYTES = sawc_pkg::DEF_LINE_BYTES,
    parameter int WAYS       = sawc_pkg::DEF_WAYS,
    parameter int SETS       = sawc_pkg::DEF_SETS,
    parameter int ADDR_BITS  = sawc_pkg::DEF_ADDR_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  sawc_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output sawc_pkg::rsp_t rsp,
    input  logic           cfg_wr_en,
    input  logic [15:0]    cfg_wr_data
);

    import sawc_pkg::*;

    localparam int OFF_W   = $clog2(LINE_BYTES);
    localparam int SET_B   = $clog2(SETS);
    localparam int SET_IW  = (SETS > 1) ? SET_B : 1;
    localparam int WAY_IW  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W   = ADDR_BITS - OFF_W - SET_B;
    localparam int LINES   = SETS * WAYS;
    localparam int LN_W    = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int DDEPTH  = LINES * LINE_BYTES;
    localparam int DA_W    = $clog2(DDEPTH);
    localparam int MDEPTH  = 1 << ADDR_BITS;

    typedef enum logic [13:0] {
        S_CLEAR    = 14'b00000000000001,
        S_IDLE     = 14'b00000000000010,
        S_TAG_RD   = 14'b00000000000100,
        S_TAG_CMP  = 14'b00000000001000,
        S_HIT_CAP  = 14'b00000000010000,
        S_MISS_CAP = 14'b00000000100000,
        S_VTAG_RD  = 14'b00000001000000,
        S_VTAG_CAP = 14'b00000010000000,
        S_WB_RD    = 14'b00000100000000,
        S_WB_WR    = 14'b00001000000000,
        S_RF_RD    = 14'b00010000000000,
        S_RF_WR    = 14'b00100000000000,
        S_NEXT     = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic                 op_reg, op_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [1:0]           size_reg, size_next;
    logic [31:0]          wdata_reg, wdata_next;
    logic [1:0]           byte_reg, byte_next;
    logic [31:0]          rdata_reg, rdata_next;
    logic [2:0]           hits_reg, hits_next;
    logic                 err_reg, err_next;
    logic [WAY_IW-1:0]    way_reg, way_next;
    logic [OFF_W-1:0]     cnt_reg, cnt_next;
    logic [TAG_W-1:0]     vtag_reg, vtag_next;
    logic [15:0]          lfsr_reg, lfsr_next;
    logic [ADDR_BITS-1:0] clr_reg, clr_next;
    logic [LINES-1:0]     valid_reg, valid_next;
    logic [LINES-1:0]     dirty_reg, dirty_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    logic [ADDR_BITS-1:0]       cur_a;
    logic [ADDR_BITS-OFF_W-1:0] line_addr;
    logic [OFF_W-1:0]           cur_off;
    logic [SET_IW-1:0]          cur_set;
    logic [TAG_W-1:0]           cur_tag;
    logic [LN_W-1:0]            cur_ln;
    logic [1:0]                 last_byte;
    logic [ADDR_BITS-1:0]       wb_addr;
    logic [ADDR_BITS-1:0]       rf_addr;

    logic                 tag_we, tag_re;
    logic [LN_W-1:0]      tag_waddr, tag_raddr;
    logic [TAG_W-1:0]     tag_rdata;
    logic                 dat_we, dat_re;
    logic [DA_W-1:0]      dat_waddr, dat_raddr;
    logic [7:0]           dat_wdata, dat_rdata;
    logic                 mem_we, mem_re;
    logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
    logic [7:0]           mem_wdata, mem_rdata;

    sawc_ram #(.DEPTH(LINES), .WIDTH(TAG_W)) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_we),
        .wr_addr (tag_waddr),
        .wr_data (cur_tag),
        .rd_en   (tag_re),
        .rd_addr (tag_raddr),
        .rd_data (tag_rdata)
    );

    sawc_ram #(.DEPTH(DDEPTH), .WIDTH(8)) u_data_ram (
        .clk     (clk),
        .wr_en   (dat_we),
        .wr_addr (dat_waddr),
        .wr_data (dat_wdata),
        .rd_en   (dat_re),
        .rd_addr (dat_raddr),
        .rd_data (dat_rdata)
    );

    sawc_ram #(.DEPTH(MDEPTH), .WIDTH(8)) u_backing_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Address split of the byte in flight
    assign cur_a     = ADDR_BITS'(addr_reg + ADDR_BITS'(byte_reg));
    assign line_addr = cur_a[ADDR_BITS-1:OFF_W];
    assign cur_off   = cur_a[OFF_W-1:0];
    assign cur_set   = SET_IW'(line_addr % SETS);
    assign cur_tag   = TAG_W'(line_addr / SETS);
    assign cur_ln    = LN_W'(32'(cur_set) * WAYS + 32'(way_reg));

    assign wb_addr = ADDR_BITS'((32'(vtag_reg) * SETS + 32'(cur_set)) * LINE_BYTES
                                + 32'(cnt_reg));
    assign rf_addr = ADDR_BITS'((32'(cur_tag) * SETS + 32'(cur_set)) * LINE_BYTES
                                + 32'(cnt_reg));

    always_comb
    begin
        case (size_reg)
            SIZE_HALF: last_byte = 2'd1;
            SIZE_WORD: last_byte = 2'd3;
            default:   last_byte = 2'd0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        size_next      = size_reg;
        wdata_next     = wdata_reg;
        byte_next      = byte_reg;
        rdata_next     = rdata_reg;
        hits_next      = hits_reg;
        err_next       = err_reg;
        way_next       = way_reg;
        cnt_next       = cnt_reg;
        vtag_next      = vtag_reg;
        lfsr_next      = lfsr_reg;
        clr_next       = clr_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        tag_we    = 1'b0;
        tag_re    = 1'b0;
        tag_waddr = cur_ln;
        tag_raddr = cur_ln;
        dat_we    = 1'b0;
        dat_re    = 1'b0;
        dat_waddr = DA_W'(32'(cur_ln) * LINE_BYTES + 32'(cur_off));
        dat_raddr = DA_W'(32'(cur_ln) * LINE_BYTES + 32'(cur_off));
        dat_wdata = wdata_reg[{byte_reg, 3'b000} +: 8];
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = cur_a;
        mem_raddr = cur_a;
        mem_wdata = wdata_reg[{byte_reg, 3'b000} +: 8];

        if (cfg_wr_en)
        begin
            lfsr_next = (cfg_wr_data == 16'd0) ? LFSR_ONE : cfg_wr_data;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 8'd0;
                clr_next  = ADDR_BITS'(clr_reg + 1'b1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.opcode;
                    addr_next  = ADDR_BITS'(req.address);
                    size_next  = req.size_code;
                    wdata_next = req.write_data;
                    byte_next  = 2'd0;
                    way_next   = '0;
                    rdata_next = 32'd0;
                    hits_next  = 3'd0;
                    err_next   = (req.size_code == SIZE_BAD);
                    state_next = (req.size_code == SIZE_BAD) ? S_DONE : S_TAG_RD;
                end
            end
            S_TAG_RD:
            begin
                tag_re     = 1'b1;
                state_next = S_TAG_CMP;
            end
            S_TAG_CMP:
            begin
                if (valid_reg[cur_ln] && (tag_rdata == cur_tag))
                begin
                    hits_next = 3'(hits_reg + 3'd1);
                    if (op_reg == OP_WRITE)
                    begin
                        dat_we             = 1'b1;
                        dirty_next[cur_ln] = 1'b1;
                        state_next         = S_NEXT;
                    end
                    else
                    begin
                        dat_re     = 1'b1;
                        state_next = S_HIT_CAP;
                    end
                end
                else if (way_reg == WAY_IW'(WAYS - 1))
                begin
                    mem_we     = (op_reg == OP_WRITE);
                    mem_re     = (op_reg == OP_READ);
                    state_next = S_MISS_CAP;
                end
                else
                begin
                    way_next   = WAY_IW'(way_reg + 1'b1);
                    state_next = S_TAG_RD;
                end
            end
            S_HIT_CAP:
            begin
                rdata_next = rdata_reg | (32'(dat_rdata) << {byte_reg, 3'b000});
                state_next = S_NEXT;
            end
            S_MISS_CAP:
            begin
                if (op_reg == OP_READ)
                begin
                    rdata_next = rdata_reg | (32'(mem_rdata) << {byte_reg, 3'b000});
                end
                // advance the LFSR once per miss, its low bits pick the victim way
                if (lfsr_reg[0])
                begin
                    lfsr_next = (lfsr_reg >> 1) ^ LFSR_TAPS;
                end
                else
                begin
                    lfsr_next = lfsr_reg >> 1;
                end
                way_next   = WAY_IW'(lfsr_next % WAYS);
                state_next = S_VTAG_RD;
            end
            S_VTAG_RD:
            begin
                cnt_next = '0;
                if (valid_reg[cur_ln] && dirty_reg[cur_ln])
                begin
                    tag_re     = 1'b1;
                    state_next = S_VTAG_CAP;
                end
                else
                begin
                    state_next = S_RF_RD;
                end
            end
            S_VTAG_CAP:
            begin
                vtag_next  = tag_rdata;
                state_next = S_WB_RD;
            end
            S_WB_RD:
            begin
                dat_re     = 1'b1;
                dat_raddr  = DA_W'(32'(cur_ln) * LINE_BYTES + 32'(cnt_reg));
                state_next = S_WB_WR;
            end
            S_WB_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = wb_addr;
                mem_wdata = dat_rdata;
                cnt_next  = OFF_W'(cnt_reg + 1'b1);
                state_next = (cnt_reg == OFF_W'(LINE_BYTES - 1)) ? S_RF_RD : S_WB_RD;
            end
            S_RF_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = rf_addr;
                state_next = S_RF_WR;
            end
            S_RF_WR:
            begin
                dat_we    = 1'b1;
                dat_waddr = DA_W'(32'(cur_ln) * LINE_BYTES + 32'(cnt_reg));
                dat_wdata = mem_rdata;
                cnt_next  = OFF_W'(cnt_reg + 1'b1);
                if (cnt_reg == OFF_W'(LINE_BYTES - 1))
                begin
                    tag_we             = 1'b1;
                    valid_next[cur_ln] = 1'b1;
                    dirty_next[cur_ln] = 1'b0;
                    state_next         = S_NEXT;
                end
                else
                begin
                    state_next = S_RF_RD;
                end
            end
            S_NEXT:
            begin
                way_next = '0;
                if (byte_reg == last_byte)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    byte_next  = 2'(byte_reg + 2'd1);
                    state_next = S_TAG_RD;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.read_data  = (op_reg == OP_WRITE || err_reg) ? 32'd0 : rdata_reg;
                    rsp_next.hit_bytes  = hits_reg;
                    rsp_next.size_error = err_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            lfsr_reg      <= LFSR_ONE;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            lfsr_reg      <= lfsr_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        addr_reg  <= addr_next;
        size_reg  <= size_next;
        wdata_reg <= wdata_next;
        byte_reg  <= byte_next;
        rdata_reg <= rdata_next;
        hits_reg  <= hits_next;
        err_reg   <= err_next;
        way_reg   <= way_next;
        cnt_reg   <= cnt_next;
        vtag_reg  <= vtag_next;
        rsp_reg   <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/sawc_ram.sv =====
// ----------------------------------------------------------------------------
// sawc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sawc_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
